// ===== rtl/core/dorf_pkg.sv =====
// Shared types and constants for the drop-oldest ring FIFO.
// Used by the channel interfaces and the top level.
package dorf_pkg;

  // Fixed field widths of the channels
  localparam int FUNC_W  = 2;
  localparam int WORD_W  = 64;
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 32;

  // Default sizing of the ring
  localparam int DEPTH_DEFAULT     = 16;
  localparam int DATA_BITS_DEFAULT = 64;

  // Capacity after reset, before it is limited to the depth
  localparam int CAP_RESET_NOMINAL = 16;

  // Operation codes; the fourth code is unused and changes no state
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH     = 2'd0,
    FUNC_TAKE     = 2'd1,
    FUNC_SHUTDOWN = 2'd2
  } func_t;

endpackage

// ===== rtl/core/dorf_in_if.sv =====
// Operation channel of the drop-oldest ring FIFO.
// Depends on dorf_pkg for field widths.
interface dorf_in_if;
  logic                       valid;
  logic                       ready;
  logic [dorf_pkg::FUNC_W-1:0] func;
  logic [dorf_pkg::WORD_W-1:0] push_data;

  modport source (output valid, output func, output push_data, input ready);
  modport sink   (input valid, input func, input push_data, output ready);
endinterface

// ===== rtl/core/dorf_out_if.sv =====
// Result channel of the drop-oldest ring FIFO.
// Depends on dorf_pkg for field widths.
interface dorf_out_if;
  logic                        valid;
  logic                        ready;
  logic [dorf_pkg::WORD_W-1:0]  read_data;
  logic                        took;
  logic                        evicted;
  logic                        closed;
  logic [dorf_pkg::CAP_W-1:0]   occupancy;
  logic [dorf_pkg::COUNT_W-1:0] dropped_total;
  logic [dorf_pkg::COUNT_W-1:0] published_total;
  logic [dorf_pkg::CAP_W-1:0]   peak_occupancy;

  modport source (output valid, output read_data, output took, output evicted,
                  output closed, output occupancy, output dropped_total,
                  output published_total, output peak_occupancy, input ready);
  modport sink   (input valid, input read_data, input took, input evicted,
                  input closed, input occupancy, input dropped_total,
                  input published_total, input peak_occupancy, output ready);
endinterface

// ===== rtl/core/dorf_cfg_if.sv =====
// Capacity write channel of the drop-oldest ring FIFO.
// Depends on dorf_pkg for the register width.
interface dorf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [dorf_pkg::CAP_W-1:0] capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== rtl/core/dorf_slots.sv =====
// Slot store of the ring: one write port, one read port, registered read data.
// Depends on no package; sized by the parameters of the top level.
module dorf_slots #(
  parameter int DEPTH     = 16,
  parameter int DATA_BITS = 64,
  parameter int IDX_W     = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/drop_oldest_ring_fifo.sv =====
// Top level of the drop-oldest ring FIFO: control, counters and result register.
// Depends on dorf_pkg, the three channel interfaces and dorf_slots.
//
//  channel  | direction | carries                              | transfer when
//  ---------+-----------+--------------------------------------+--------------------
//  in_ch    | sink      | func, push_data                      | valid && ready
//  out_ch   | source    | read_data, flags, occupancy, totals  | valid && ready
//  cfg_ch   | sink      | capacity_in_use                      | valid (ready tied 1)
//
// Push, shutdown and the unused code have their result registered at
// the accepting edge, and a new operation is taken while it is being read out.
// A take that pops an entry sets pend at the accepting edge while the slot store
// registers the read data, and the result is raised from pend; a take from an empty ring is registered like a push.
// Reset (rst, synchronous) clears indices, counters, the stopped flag and the result
// handshake and sets the capacity to 16 or DEPTH if smaller; slot contents are not cleared.
// A stalled result holds the input side off until it is taken.
module drop_oldest_ring_fifo #(
  parameter int DEPTH     = dorf_pkg::DEPTH_DEFAULT,
  parameter int DATA_BITS = dorf_pkg::DATA_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dorf_in_if.sink    in_ch,
  dorf_out_if.source out_ch,
  dorf_cfg_if.sink   cfg_ch
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CAP_W   = dorf_pkg::CAP_W;
  localparam int COUNT_W = dorf_pkg::COUNT_W;
  localparam int WORD_W  = dorf_pkg::WORD_W;
  localparam int CMP_W   = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
  localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam int CAP_RST = (dorf_pkg::CAP_RESET_NOMINAL > DEPTH) ? DEPTH
                         : dorf_pkg::CAP_RESET_NOMINAL;

  localparam logic [CAP_W-1:0] CAP_MAX_V = CAP_W'(CAP_MAX);
  localparam logic [CAP_W-1:0] CAP_RST_V = CAP_W'(CAP_RST);
  localparam logic [CAP_W-1:0] CAP_MIN_V = CAP_W'(1);

  // Ring state
  logic [CAP_W-1:0]   capacity;
  logic [IDX_W-1:0]   read_index,   read_index_next;
  logic [IDX_W-1:0]   write_index,  write_index_next;
  logic [CAP_W-1:0]   fill_count,   fill_count_next;
  logic [COUNT_W-1:0] drop_counter, drop_counter_next;
  logic [COUNT_W-1:0] push_counter, push_counter_next;
  logic [CAP_W-1:0]   high_watermark, high_watermark_next;
  logic               stopped,      stopped_next;

  // Result register and pending read
  logic               pend;
  logic               out_valid;
  logic               res_took,    res_took_next;
  logic               res_evicted, res_evicted_next;
  logic               res_closed,  res_closed_next;
  logic [CAP_W-1:0]   res_occupancy;
  logic [COUNT_W-1:0] res_dropped;
  logic [COUNT_W-1:0] res_published;
  logic [CAP_W-1:0]   res_peak;

  // Slot store ports
  logic                 wr_en, rd_en;
  logic [DATA_BITS-1:0] rd_data;

  logic             in_fire, cfg_fire;
  logic [IDX_W-1:0] rd_adv, wr_adv;
  logic [CAP_W-1:0] fill_push, cap_clamped;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready  = !pend && (!out_valid || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // Index advance with wrap at the capacity in use
  always_comb begin
    rd_adv = (CMP_W'(read_index) + CMP_W'(1) >= CMP_W'(capacity)) ? '0
           : read_index + IDX_W'(1);
    wr_adv = (CMP_W'(write_index) + CMP_W'(1) >= CMP_W'(capacity)) ? '0
           : write_index + IDX_W'(1);
  end

  // Occupancy after a push, eviction included
  assign fill_push = (fill_count >= capacity) ? fill_count : fill_count + CAP_W'(1);

  // Operation decode and next state
  always_comb begin
    read_index_next     = read_index;
    write_index_next    = write_index;
    fill_count_next     = fill_count;
    drop_counter_next   = drop_counter;
    push_counter_next   = push_counter;
    high_watermark_next = high_watermark;
    stopped_next        = stopped;
    res_took_next       = 1'b0;
    res_evicted_next    = 1'b0;
    res_closed_next     = 1'b0;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    if (in_fire) begin
      case (in_ch.func)
        dorf_pkg::FUNC_PUSH: begin
          wr_en = 1'b1;
          if (fill_count >= capacity) begin
            read_index_next   = rd_adv;
            drop_counter_next = drop_counter + COUNT_W'(1);
            res_evicted_next  = 1'b1;
          end
          write_index_next  = wr_adv;
          fill_count_next   = fill_push;
          push_counter_next = push_counter + COUNT_W'(1);
          if (fill_push > high_watermark) begin
            high_watermark_next = fill_push;
          end
        end
        dorf_pkg::FUNC_TAKE: begin
          if (fill_count != '0) begin
            rd_en           = 1'b1;
            read_index_next = rd_adv;
            fill_count_next = fill_count - CAP_W'(1);
            res_took_next   = 1'b1;
          end else begin
            res_closed_next = stopped;
          end
        end
        dorf_pkg::FUNC_SHUTDOWN: begin
          stopped_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp of a written capacity to 1..DEPTH, or to 1..31 if DEPTH is larger
  always_comb begin
    if (cfg_ch.capacity_in_use < CAP_MIN_V) begin
      cap_clamped = CAP_MIN_V;
    end else if (cfg_ch.capacity_in_use > CAP_MAX_V) begin
      cap_clamped = CAP_MAX_V;
    end else begin
      cap_clamped = cfg_ch.capacity_in_use;
    end
  end

  // State registers; a capacity write counts only while the ring is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RST_V;
      read_index     <= '0;
      write_index    <= '0;
      fill_count     <= '0;
      drop_counter   <= '0;
      push_counter   <= '0;
      high_watermark <= '0;
      stopped        <= 1'b0;
    end else begin
      read_index     <= read_index_next;
      write_index    <= write_index_next;
      fill_count     <= fill_count_next;
      drop_counter   <= drop_counter_next;
      push_counter   <= push_counter_next;
      high_watermark <= high_watermark_next;
      stopped        <= stopped_next;
      if (cfg_fire && fill_count == '0) begin
        capacity    <= cap_clamped;
        read_index  <= '0;
        write_index <= '0;
      end
    end
  end

  // Result handshake: a popping take waits in pend for the registered slot data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (in_fire) begin
      out_valid <= !res_took_next;
      pend      <= res_took_next;
    end else if (pend) begin
      out_valid <= 1'b1;
      pend      <= 1'b0;
    end else if (out_valid && out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_took      <= res_took_next;
      res_evicted   <= res_evicted_next;
      res_closed    <= res_closed_next;
      res_occupancy <= fill_count_next;
      res_dropped   <= drop_counter_next;
      res_published <= push_counter_next;
      res_peak      <= high_watermark_next;
    end
  end

  dorf_slots #(
    .DEPTH     (DEPTH),
    .DATA_BITS (DATA_BITS),
    .IDX_W     (IDX_W)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_index),
    .wr_data (in_ch.push_data[DATA_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (read_index),
    .rd_data (rd_data)
  );

  // Output channel
  assign out_ch.valid           = out_valid;
  assign out_ch.read_data       = res_took ? WORD_W'(rd_data) : '0;
  assign out_ch.took            = res_took;
  assign out_ch.evicted         = res_evicted;
  assign out_ch.closed          = res_closed;
  assign out_ch.occupancy       = res_occupancy;
  assign out_ch.dropped_total   = res_dropped;
  assign out_ch.published_total = res_published;
  assign out_ch.peak_occupancy  = res_peak;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the drop-oldest ring FIFO: directed table, then random phases.
// Depends on dorf_pkg, the three channel interfaces and drop_oldest_ring_fifo.
`timescale 1ns / 100ps

module tb_top;

  localparam int FUNC_W     = dorf_pkg::FUNC_W;
  localparam int WORD_W     = dorf_pkg::WORD_W;
  localparam int CAP_W      = dorf_pkg::CAP_W;
  localparam int COUNT_W    = dorf_pkg::COUNT_W;
  localparam int DEPTH      = dorf_pkg::DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES     = 8;
  localparam int PHASE_OPS  = 140;

  // Unused operation code: the block reports state and changes nothing
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One result item, field order as on the result channel
  typedef struct packed {
    logic [WORD_W-1:0]  read_data;
    logic               took;
    logic               evicted;
    logic               closed;
    logic [CAP_W-1:0]   occupancy;
    logic [COUNT_W-1:0] dropped_total;
    logic [COUNT_W-1:0] published_total;
    logic [CAP_W-1:0]   peak_occupancy;
  } ring_result_t;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

  // Directed stimulus row; fixed rows carry a hand-written result
  typedef struct packed {
    row_kind_t          kind;
    logic [FUNC_W-1:0]  func;
    logic [WORD_W-1:0]  data;
    logic [CAP_W-1:0]   cap;
    logic               fixed;
    ring_result_t       want;
  } stim_row_t;

  logic clk;
  logic rst;

  dorf_in_if  in_ch ();
  dorf_out_if out_ch ();
  dorf_cfg_if cfg_ch ();

  drop_oldest_ring_fifo #(
    .DEPTH     (DEPTH),
    .DATA_BITS (dorf_pkg::DATA_BITS_DEFAULT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted ring state
  logic [WORD_W-1:0]  ring_slots [DEPTH];
  logic [3:0]         ring_rd;
  logic [3:0]         ring_wr;
  logic [CAP_W-1:0]   ring_fill;
  logic [CAP_W-1:0]   ring_cap;
  logic [CAP_W-1:0]   ring_peak;
  logic [COUNT_W-1:0] ring_drops;
  logic [COUNT_W-1:0] ring_pushes;
  logic               ring_stopped;

  ring_result_t expected_results [$];
  stim_row_t    directed_rows [$];
  int           mismatches;
  int           idle_cycles;
  bit           src_quiet;
  bit           sink_quiet;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [3:0] next_slot(logic [3:0] idx);
    return ({1'b0, idx} + 5'd1 >= ring_cap) ? 4'd0 : idx + 4'd1;
  endfunction

  function automatic void ring_clear();
    ring_rd      = '0;
    ring_wr      = '0;
    ring_fill    = '0;
    ring_peak    = '0;
    ring_drops   = '0;
    ring_pushes  = '0;
    ring_stopped = 1'b0;
    ring_cap     = (dorf_pkg::CAP_RESET_NOMINAL > DEPTH) ? CAP_W'(DEPTH)
                 : CAP_W'(dorf_pkg::CAP_RESET_NOMINAL);
  endfunction

  // Capacity write: clamped to 1..DEPTH, dropped unless the ring is empty
  function automatic void ring_set_capacity(logic [CAP_W-1:0] v);
    if (ring_fill != 0) return;
    if (v == 0) ring_cap = 5'd1;
    else if (v > DEPTH) ring_cap = CAP_W'(DEPTH);
    else ring_cap = v;
    ring_rd = '0;
    ring_wr = '0;
  endfunction

  function automatic ring_result_t predict_ring_op(logic [FUNC_W-1:0] f,
                                                   logic [WORD_W-1:0] d);
    ring_result_t r;
    r = '0;
    case (f)
      dorf_pkg::FUNC_PUSH: begin
        // full ring: drop the oldest before storing
        if (ring_fill >= ring_cap) begin
          ring_rd    = next_slot(ring_rd);
          ring_fill  = ring_fill - 1'b1;
          ring_drops = ring_drops + 1'b1;
          r.evicted  = 1'b1;
        end
        ring_slots[ring_wr] = d;
        ring_wr     = next_slot(ring_wr);
        ring_fill   = ring_fill + 1'b1;
        ring_pushes = ring_pushes + 1'b1;
        if (ring_fill > ring_peak) ring_peak = ring_fill;
      end
      dorf_pkg::FUNC_TAKE: begin
        if (ring_fill != 0) begin
          r.read_data = ring_slots[ring_rd];
          r.took      = 1'b1;
          ring_rd     = next_slot(ring_rd);
          ring_fill   = ring_fill - 1'b1;
        end else if (ring_stopped) begin
          r.closed = 1'b1;
        end
      end
      dorf_pkg::FUNC_SHUTDOWN: ring_stopped = 1'b1;
      default: ;
    endcase
    r.occupancy       = ring_fill;
    r.dropped_total   = ring_drops;
    r.published_total = ring_pushes;
    r.peak_occupancy  = ring_peak;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    mismatches++;
    $display("%0t ns: %s got %h, want %h", $time, field, got, want);
  endtask

  task automatic check_result(ring_result_t got);
    ring_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending", got.read_data, '0);
      return;
    end
    want = expected_results.pop_front();
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
    if (got.took !== want.took)
      report_mismatch("took", got.took, want.took);
    if (got.evicted !== want.evicted)
      report_mismatch("evicted", got.evicted, want.evicted);
    if (got.closed !== want.closed)
      report_mismatch("closed", got.closed, want.closed);
    if (got.occupancy !== want.occupancy)
      report_mismatch("occupancy", got.occupancy, want.occupancy);
    if (got.dropped_total !== want.dropped_total)
      report_mismatch("dropped_total", got.dropped_total, want.dropped_total);
    if (got.published_total !== want.published_total)
      report_mismatch("published_total", got.published_total, want.published_total);
    if (got.peak_occupancy !== want.peak_occupancy)
      report_mismatch("peak_occupancy", got.peak_occupancy, want.peak_occupancy);
  endtask

  // Result side: random stalls per transfer, quiet stretches when asked
  initial begin
    int stall;
    ring_result_t got;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = sink_quiet ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got.read_data       = out_ch.read_data;
      got.took            = out_ch.took;
      got.evicted         = out_ch.evicted;
      got.closed          = out_ch.closed;
      got.occupancy       = out_ch.occupancy;
      got.dropped_total   = out_ch.dropped_total;
      got.published_total = out_ch.published_total;
      got.peak_occupancy  = out_ch.peak_occupancy;
      check_result(got);
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic stim_row_t op_row(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] d);
    return '{ROW_OP, f, d, 5'd0, 1'b0, ring_result_t'('0)};
  endfunction

  function automatic stim_row_t fixed_row(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] d,
                                          ring_result_t want);
    return '{ROW_OP, f, d, 5'd0, 1'b1, want};
  endfunction

  function automatic stim_row_t cap_row(logic [CAP_W-1:0] v);
    return '{ROW_CAP, FUNC_UNUSED, 64'd0, v, 1'b0, ring_result_t'('0)};
  endfunction

  // One operation transfer; the expectation is queued at the accepting edge
  task automatic issue_op(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] d,
                          logic use_fixed, ring_result_t fixed_res);
    int gap;
    ring_result_t predicted;
    gap = src_quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.push_data <= d;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_ring_op(f, d);
    expected_results.push_back(use_fixed ? fixed_res : predicted);
  endtask

  // Capacity write once every result is out and the block has settled
  task automatic write_capacity(logic [CAP_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ring_set_capacity(v);
  endtask

  initial begin
    logic [CAP_W-1:0]  phase_caps [PHASES];
    logic [FUNC_W-1:0] f;
    int push_pct;
    int pick;

    in_ch.valid            <= 1'b0;
    in_ch.func             <= dorf_pkg::FUNC_PUSH;
    in_ch.push_data        <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.capacity_in_use <= '0;
    rst                    <= 1'b1;
    mismatches  = 0;
    idle_cycles = 0;
    src_quiet   = 1'b0;
    sink_quiet  = 1'b0;
    ring_clear();

    // Reset state, extremes of data, capacity clamps, ignored write,
    // eviction, shutdown and closed takes, unused code
    directed_rows = '{
      fixed_row(dorf_pkg::FUNC_TAKE, 64'd0,
                ring_result_t'{64'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0, 5'd0}),
      fixed_row(FUNC_UNUSED, 64'd0,
                ring_result_t'{64'd0, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0, 5'd0}),
      fixed_row(dorf_pkg::FUNC_PUSH, 64'd0,
                ring_result_t'{64'd0, 1'b0, 1'b0, 1'b0, 5'd1, 32'd0, 32'd1, 5'd1}),
      fixed_row(dorf_pkg::FUNC_PUSH, '1,
                ring_result_t'{64'd0, 1'b0, 1'b0, 1'b0, 5'd2, 32'd0, 32'd2, 5'd2}),
      fixed_row(dorf_pkg::FUNC_TAKE, 64'd0,
                ring_result_t'{64'd0, 1'b1, 1'b0, 1'b0, 5'd1, 32'd0, 32'd2, 5'd2}),
      fixed_row(dorf_pkg::FUNC_TAKE, 64'd0,
                ring_result_t'{'1, 1'b1, 1'b0, 1'b0, 5'd0, 32'd0, 32'd2, 5'd2}),
      cap_row(5'd0),
      op_row(dorf_pkg::FUNC_PUSH, 64'h0123_4567_89ab_cdef),
      op_row(dorf_pkg::FUNC_PUSH, 64'hfedc_ba98_7654_3210),
      cap_row(5'd5),
      op_row(dorf_pkg::FUNC_PUSH, 64'haaaa_aaaa_aaaa_aaaa),
      op_row(dorf_pkg::FUNC_TAKE, 64'd0),
      cap_row(5'd2),
      op_row(dorf_pkg::FUNC_PUSH, 64'h5555_5555_5555_5555),
      op_row(dorf_pkg::FUNC_PUSH, 64'h8000_0000_0000_0001),
      op_row(dorf_pkg::FUNC_PUSH, 64'd1),
      op_row(dorf_pkg::FUNC_TAKE, '1),
      op_row(dorf_pkg::FUNC_SHUTDOWN, 64'h1234_5678_9abc_def0),
      op_row(dorf_pkg::FUNC_TAKE, 64'd0),
      op_row(dorf_pkg::FUNC_TAKE, 64'd0),
      op_row(dorf_pkg::FUNC_PUSH, 64'hdead_beef_0000_ffff),
      op_row(dorf_pkg::FUNC_TAKE, 64'd0),
      op_row(FUNC_UNUSED, 64'hffff_0000_ffff_0000),
      cap_row(5'd31)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAP)
        write_capacity(directed_rows[i].cap);
      else
        issue_op(directed_rows[i].func, directed_rows[i].data,
                 directed_rows[i].fixed, directed_rows[i].want);
    end

    // Random phases, each with its own capacity, mix and idling
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd16};
    phase_caps[PHASES-1] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < PHASES; p++) begin
      // usually empty the ring first so the write takes effect
      if (p == 0 || $urandom_range(0, 3) != 0) begin
        while (ring_fill != 0)
          issue_op(dorf_pkg::FUNC_TAKE, {$urandom, $urandom}, 1'b0, '0);
      end
      write_capacity(phase_caps[p]);
      src_quiet  = ($urandom_range(0, 2) == 0);
      sink_quiet = ($urandom_range(0, 2) == 0);
      push_pct   = $urandom_range(25, 75);
      for (int n = 0; n < PHASE_OPS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) f = FUNC_UNUSED;
        else if (pick < 3) f = dorf_pkg::FUNC_SHUTDOWN;
        else if (pick < 3 + push_pct) f = dorf_pkg::FUNC_PUSH;
        else f = dorf_pkg::FUNC_TAKE;
        issue_op(f, {$urandom, $urandom}, 1'b0, '0);
      end
    end

    // Drain and settle
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dorf_pkg.sv
rtl/core/dorf_in_if.sv
rtl/core/dorf_out_if.sv
rtl/core/dorf_cfg_if.sv
rtl/core/dorf_slots.sv
rtl/core/drop_oldest_ring_fifo.sv
test/tb_top.sv
